>>> rtl/core/clqp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clqp_pkg
// Shared widths, codes and types of the color table quantizer and 4bpp packer.
// ----------------------------------------------------------------------------
package clqp_pkg;

	localparam int BYTE_W     = 8;
	localparam int CODE_W     = 4;
	localparam int TADDR_W    = 12;
	localparam int TDATA_W    = 40;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	localparam logic OP_PIXEL       = 1'b0;
	localparam logic OP_TABLE_WRITE = 1'b1;

	localparam logic ORDER_RGB = 1'b0;
	localparam logic ORDER_BGR = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ORDER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_CODE      = 2'd1;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t ent;
	} beat_t;

endpackage

>>> rtl/core/clqp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clqp_front
// Accepts beats, writes the color table or looks up a pixel code.
// ----------------------------------------------------------------------------
module clqp_front #(
	parameter int COLOR_BITS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          channel_order,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_op,
	input  logic [clqp_pkg::TDATA_W-1:0]  in_data,
	input  logic                          in_last,
	input  logic [clqp_pkg::Q_CNT_W-1:0]  q_level,
	output clqp_pkg::beat_t               push
);
	import clqp_pkg::*;

	localparam int ADDR_W = 3 * COLOR_BITS;
	localparam int DEPTH  = 1 << ADDR_W;

	logic [CODE_W-1:0]  color_table_q [DEPTH];
	logic [BYTE_W-1:0]  byte_first, byte_middle, byte_third, red, blue;
	logic [TADDR_W-1:0] table_address;
	logic [CODE_W-1:0]  table_code;
	logic [ADDR_W-1:0]  rd_addr, wr_addr;
	logic [Q_CNT_W:0]   used;
	logic               accept, wr_en, rd_en;
	logic               valid_s1, last_s1;
	logic [CODE_W-1:0]  code_s1;

	assign byte_first    = in_data[BYTE_W-1:0];
	assign byte_middle   = in_data[2*BYTE_W-1:BYTE_W];
	assign byte_third    = in_data[3*BYTE_W-1:2*BYTE_W];
	assign table_address = in_data[3*BYTE_W +: TADDR_W];
	assign table_code    = in_data[3*BYTE_W+TADDR_W +: CODE_W];

	assign red  = (channel_order == ORDER_BGR) ? byte_third : byte_first;
	assign blue = (channel_order == ORDER_BGR) ? byte_first : byte_third;

	assign rd_addr = {red[BYTE_W-1 -: COLOR_BITS], byte_middle[BYTE_W-1 -: COLOR_BITS],
		blue[BYTE_W-1 -: COLOR_BITS]};
	assign wr_addr = ADDR_W'(table_address);

	// reserve a queue slot for the lookup in flight
	assign used     = {1'b0, q_level} + (Q_CNT_W+1)'(valid_s1);
	assign in_ready = used < (Q_CNT_W+1)'(Q_DEPTH);

	assign accept = in_valid && in_ready;
	assign wr_en  = accept && (in_op == OP_TABLE_WRITE);
	assign rd_en  = accept && (in_op == OP_PIXEL);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			color_table_q[wr_addr] <= table_code;
		end
		if (rd_en) begin
			code_s1 <= color_table_q[rd_addr];
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
		end
	end

	assign push.valid    = valid_s1;
	assign push.ent.code = code_s1;
	assign push.ent.last = last_s1;

endmodule

>>> rtl/core/clqp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clqp_fifo
// Short queue of looked-up codes between the front and the packer.
// ----------------------------------------------------------------------------
module clqp_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  clqp_pkg::beat_t               push,
	input  logic                          pop,
	output clqp_pkg::beat_t               head,
	output logic [clqp_pkg::Q_CNT_W-1:0]  level
);
	import clqp_pkg::*;

	entry_t             slots_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slots_q[wr_ptr_q] <= push.ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			cnt_q <= cnt_q + Q_CNT_W'(push.valid) - Q_CNT_W'(pop);
		end
	end

	assign head.valid = cnt_q != '0;
	assign head.ent   = slots_q[rd_ptr_q];
	assign level      = cnt_q;

endmodule

>>> rtl/core/clqp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clqp_back
// Pairs codes into bytes, pads an odd final pixel, drives the output register.
// ----------------------------------------------------------------------------
module clqp_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [clqp_pkg::CODE_W-1:0]     pad_code,
	input  clqp_pkg::beat_t                 head,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2*clqp_pkg::CODE_W-1:0]   out_data,
	output logic                            out_last
);
	import clqp_pkg::*;

	logic [CODE_W-1:0]   held_code_q;
	logic                held_valid_q;
	logic                out_valid_q, out_last_q;
	logic [2*CODE_W-1:0] out_data_q;
	logic                emits, out_free, fire;

	assign emits    = held_valid_q || head.ent.last;
	assign out_free = !out_valid_q || out_ready;
	assign pop      = head.valid && (!emits || out_free);
	assign fire     = pop && emits;

	always_ff @(posedge clk) begin
		if (fire) begin
			if (held_valid_q) begin
				out_data_q <= {held_code_q, head.ent.code};
				out_last_q <= head.ent.last;
			end else begin
				out_data_q <= {head.ent.code, pad_code};
				out_last_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			held_valid_q <= 1'b0;
			held_code_q  <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= fire;
			end
			if (pop) begin
				if (held_valid_q) begin
					held_valid_q <= 1'b0;
					held_code_q  <= '0;
				end else if (!head.ent.last) begin
					held_valid_q <= 1'b1;
					held_code_q  <= head.ent.code;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

>>> rtl/core/color_lut_quantize_pack_4bpp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_lut_quantize_pack_4bpp
// Color table quantizer: pixel to 4-bit palette code, two codes per byte.
// ----------------------------------------------------------------------------
// channel  dir  handshake                    content
// s_axis   in   s_axis_tvalid/s_axis_tready  pixel or table write beat
// m_axis   out  m_axis_tvalid/m_axis_tready  packed byte, tlast ends the run
// cfg      in   cfg_valid/cfg_ready          register index and data
//
// One beat per cycle while s_axis_tready is high. A pixel that completes a byte
// reaches m_axis through table read, queue write and output register load.
// Reset clears control state only; the table holds no value until written.
// A four-entry queue with slot reservation lets the front and the packer
// stall apart; s_axis_tready drops only when queued and in-flight codes fill it.
// ----------------------------------------------------------------------------
module color_lut_quantize_pack_4bpp #(
	parameter int COLOR_BITS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [7:0] byte_first, [15:8] byte_middle, [23:16] byte_third,
	// [35:24] table_address, [39:36] table_code
	input  logic [clqp_pkg::TDATA_W-1:0]      s_axis_tdata,
	// [0] operation
	input  logic                              s_axis_tuser,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [7:0] packed_byte
	output logic [2*clqp_pkg::CODE_W-1:0]     m_axis_tdata,
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [clqp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [clqp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import clqp_pkg::*;

	logic               channel_order_q;
	logic [CODE_W-1:0]  pad_code_q;
	beat_t              push, head;
	logic               pop;
	logic [Q_CNT_W-1:0] q_level;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_order_q <= ORDER_RGB;
			pad_code_q      <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CHANNEL_ORDER: channel_order_q <= cfg_data[0];
				CFG_PAD_CODE:      pad_code_q      <= cfg_data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	clqp_front #(
		.COLOR_BITS(COLOR_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.channel_order (channel_order_q),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_op         (s_axis_tuser),
		.in_data       (s_axis_tdata),
		.in_last       (s_axis_tlast),
		.q_level       (q_level),
		.push          (push)
	);

	clqp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.level  (q_level)
	);

	clqp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pad_code  (pad_code_q),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.valid && q_level == Q_CNT_W'(Q_DEPTH) && !pop))
		else $error("queue overflow");

	a_pixel_pushed: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_PIXEL) |=> push.valid)
		else $error("pixel lookup lost");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_TABLE_WRITE) |=> !push.valid)
		else $error("table write produced a code");

endmodule

>>> sim/color_lut_quantize_pack_4bpp_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_lut_quantize_pack_4bpp_check
// Watches the pixel, packed byte and register channels of the color table
// quantizer. Keeps its own copy of the color table, the held nibble and the
// registers, predicts every packed byte from the accepted beats, and compares
// each output beat in order against the oldest prediction.
// ----------------------------------------------------------------------------
module color_lut_quantize_pack_4bpp_check
	import clqp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// [7:0] byte_first, [15:8] byte_middle, [23:16] byte_third,
	// [35:24] table_address, [39:36] table_code
	input  logic [TDATA_W-1:0]    s_axis_tdata,
	// [0] operation
	input  logic                  s_axis_tuser,
	input  logic                  s_axis_tlast,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [7:0] packed_byte
	input  logic [2*CODE_W-1:0]   m_axis_tdata,
	input  logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	localparam int COLOR_BITS = 4;
	localparam int LUT_DEPTH  = 1 << (3 * COLOR_BITS);

	typedef struct packed {
		logic [CODE_W-1:0]  table_code;
		logic [TADDR_W-1:0] table_address;
		logic [BYTE_W-1:0]  byte_third;
		logic [BYTE_W-1:0]  byte_middle;
		logic [BYTE_W-1:0]  byte_first;
	} pixel_word_t;

	typedef struct packed {
		logic [2*CODE_W-1:0] packed_byte;
		logic                run_end;
	} packed_beat_t;

	logic [CODE_W-1:0] lut_copy [LUT_DEPTH];
	logic [CODE_W-1:0] held_code;
	logic              held_valid;
	logic              channel_order;
	logic [CODE_W-1:0] pad_code;
	packed_beat_t      packed_byte_q [$];
	int                errors = 0;

	initial pending = 0;
	assign fail_count = errors;

	function automatic int lut_slot(logic [BYTE_W-1:0] red, logic [BYTE_W-1:0] green,
		logic [BYTE_W-1:0] blue);
		return {red[BYTE_W-1 -: COLOR_BITS], green[BYTE_W-1 -: COLOR_BITS],
			blue[BYTE_W-1 -: COLOR_BITS]};
	endfunction

	task automatic quantize_beat(logic op, pixel_word_t word, logic last);
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] blue;
		logic [CODE_W-1:0] code;
		if (op == OP_TABLE_WRITE) begin
			lut_copy[int'(word.table_address) % LUT_DEPTH] = word.table_code;
			return;
		end
		red = (channel_order == ORDER_BGR) ? word.byte_third : word.byte_first;
		blue = (channel_order == ORDER_BGR) ? word.byte_first : word.byte_third;
		code = lut_copy[lut_slot(red, word.byte_middle, blue)];
		if (held_valid) begin
			packed_byte_q.push_back('{{held_code, code}, last});
			held_valid = 1'b0;
			held_code = '0;
		end else if (last) begin
			packed_byte_q.push_back('{{code, pad_code}, 1'b1});
		end else begin
			held_code = code;
			held_valid = 1'b1;
		end
	endtask

	task automatic note_failure(string what, packed_beat_t want);
		errors++;
		if (errors <= 10) begin
			$display("%0t: %s: expected %02h last %0b, got %02h last %0b", $realtime, what,
				want.packed_byte, want.run_end, m_axis_tdata, m_axis_tlast);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_code = '0;
			held_valid = 1'b0;
			channel_order = ORDER_RGB;
			pad_code = '0;
			packed_byte_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_CHANNEL_ORDER) begin
					channel_order = cfg_data[0];
				end else if (cfg_index == CFG_PAD_CODE) begin
					pad_code = cfg_data[CODE_W-1:0];
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				quantize_beat(s_axis_tuser, s_axis_tdata, s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (packed_byte_q.size() == 0) begin
					note_failure("unexpected packed byte", '0);
				end else if (m_axis_tdata !== packed_byte_q[0].packed_byte
					|| m_axis_tlast !== packed_byte_q[0].run_end) begin
					note_failure("packed byte mismatch", packed_byte_q.pop_front());
				end else begin
					void'(packed_byte_q.pop_front());
				end
			end
			pending <= packed_byte_q.size();
		end
	end

endmodule

>>> sim/color_lut_quantize_pack_4bpp_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_lut_quantize_pack_4bpp_test
// Loads the color table, then streams pixels in both channel orders and with
// several pad codes: a directed run over extreme colors, pairing, odd and even
// run ends and table writes between paired pixels, then random runs whose
// pixels only hit loaded entries; both stream sides idle at random in the first two.
// ----------------------------------------------------------------------------
module color_lut_quantize_pack_4bpp_test;
	import clqp_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [TDATA_W-1:0]    s_axis_tdata = '0;
	logic                  s_axis_tuser = OP_PIXEL;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [2*CODE_W-1:0]   m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_CHANNEL_ORDER;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    fail_count;
	int                    pending;
	int                    send_idle_pct = 0;
	int                    recv_idle_pct = 0;
	logic                  channel_order = ORDER_RGB;
	bit                    lut_loaded [1 << TADDR_W];
	logic [TADDR_W-1:0]    loaded_slots [$];

	color_lut_quantize_pack_4bpp i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	color_lut_quantize_pack_4bpp_check i_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic push_beat(logic op, logic [TDATA_W-1:0] data, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= data;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic load_entry(logic [TADDR_W-1:0] slot, logic [CODE_W-1:0] code);
		if (!lut_loaded[slot]) begin
			lut_loaded[slot] = 1'b1;
			loaded_slots.push_back(slot);
		end
		push_beat(OP_TABLE_WRITE, {code, slot, 24'($urandom)}, 1'($urandom));
	endtask

	task automatic send_pixel(logic [BYTE_W-1:0] red, logic [BYTE_W-1:0] green,
		logic [BYTE_W-1:0] blue, logic last);
		logic [BYTE_W-1:0] first;
		logic [BYTE_W-1:0] third;
		first = (channel_order == ORDER_BGR) ? blue : red;
		third = (channel_order == ORDER_BGR) ? red : blue;
		push_beat(OP_PIXEL, {4'($urandom), 12'($urandom), third, green, first}, last);
	endtask

	// fill the low bits of each channel at random, the table slot fixes the top
	task automatic send_slot(logic [TADDR_W-1:0] slot, logic last);
		send_pixel({slot[11:8], 4'($urandom)}, {slot[7:4], 4'($urandom)},
			{slot[3:0], 4'($urandom)}, last);
	endtask

	task automatic set_config(logic order, logic [CODE_W-1:0] pad);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_CHANNEL_ORDER;
		cfg_data <= CFG_DATA_W'(order);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_PAD_CODE;
		cfg_data <= pad;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		channel_order = order;
	endtask

	task automatic drain(int extra);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic random_run(int beats);
		for (int i = 0; i < beats; i++) begin
			if (i == 60) begin
				drain(0);
			end
			if ($urandom_range(3) == 0) begin
				load_entry(TADDR_W'($urandom), CODE_W'($urandom));
			end else begin
				send_slot(loaded_slots[$urandom_range(loaded_slots.size() - 1)],
					$urandom_range(5) == 0);
			end
		end
		send_slot(loaded_slots[$urandom_range(loaded_slots.size() - 1)], 1'b1);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_config(ORDER_RGB, 4'd9);

		load_entry(12'h000, 4'hF);
		load_entry(12'hFFF, 4'h0);
		load_entry(12'hF00, 4'h5);
		load_entry(12'h00F, 4'hA);
		load_entry(12'h0F0, 4'h3);
		send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_pixel(8'hFF, 8'h00, 8'h00, 1'b1);
		send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
		// table write between the two pixels of a pair
		push_beat(OP_TABLE_WRITE, {4'h7, 12'h123, 24'hFFFFFF}, 1'b1);
		lut_loaded[12'h123] = 1'b1;
		loaded_slots.push_back(12'h123);
		send_pixel(8'h1F, 8'h2F, 8'h3F, 1'b0);
		send_pixel(8'h00, 8'hFF, 8'h00, 1'b1);
		send_pixel(8'h0F, 8'h0F, 8'h0F, 1'b0);
		send_pixel(8'hF0, 8'hF0, 8'hF0, 1'b1);
		load_entry(12'hFFF, 4'hC);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_pixel(8'h12, 8'h23, 8'h34, 1'b1);
		drain(8);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 29;
					recv_idle_pct <= 60;
					set_config(ORDER_BGR, 4'hF);
				end
				1: begin
					send_idle_pct = 60;
					recv_idle_pct <= 29;
					set_config(ORDER_RGB, 4'h0);
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
					set_config(1'($urandom), 4'($urandom));
				end
			endcase
			random_run(135);
			drain(8);
		end

		drain(20);
		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
